// ----- design/mfb_pkg.sv -----
// ----------------------------------------------------------------------------
// mfb_pkg: shared types and constants of the Morlet filter bank convolver
// Request payload structs, register indexes, mode codes and sum limits.
// ----------------------------------------------------------------------------
package mfb_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WINDOW   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALES_IN_USE = 1'b1;

  localparam logic [9:0] HALF_WINDOW_RST   = 10'd428;
  localparam logic [4:0] SCALES_IN_USE_RST = 5'd11;

  // Request modes
  localparam logic MODE_COEF   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // Effective half window needs one bit more than the register
  localparam int HEFF_W = 11;

  // Warmup counter
  localparam int         WARM_W   = 10;
  localparam logic [9:0] WARM_MAX = 10'd1023;

  // Output sums
  localparam int                       SUM_W   = 40;
  localparam logic signed [SUM_W-1:0]  SUM_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [SUM_W-1:0]  SUM_MIN = 40'sh80_0000_0000;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] sample;
    logic [3:0]         coef_scale;
    logic [8:0]         coef_tap;
    logic signed [15:0] coef_real;
    logic signed [15:0] coef_imag;
  } in_t;

  typedef struct packed {
    logic [3:0]              scale_out;
    logic signed [SUM_W-1:0] real_sum;
    logic signed [SUM_W-1:0] imag_sum;
    logic                    last_scale;
  } out_t;

  // Sample line control
  typedef struct packed {
    logic push;
    logic rewind;
    logic step;
  } line_ctl_t;

  // Multiply-accumulate control, issued with the memory reads
  typedef struct packed {
    logic valid;
    logic first;
    logic sub;
  } mac_ctl_t;

endpackage

// ----- design/morlet_filter_bank_convolver_top.sv -----
// ----------------------------------------------------------------------------
// morlet_filter_bank_convolver_top: complex Morlet FIR filter bank
// Coefficient loads and samples in; one real/imaginary sum pair per scale out.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+--------------
//   in      | input     | in_valid_i / in_ready_o   | in_i  (in_t)
//   out     | output    | out_valid_o / out_ready_i | out_o (out_t)
//   cfg     | input     | cfg_we_i (no wait)        | cfg_idx_i, cfg_wdata_i
//
// A coefficient write or a warmup sample leaves the block ready for the next
// request. A sample with results runs every scale in use over its taps: the shared multiply-
// accumulate takes one tap per cycle from the sample line and tap table read
// ports, and each scale then drains the read and multiply stages.
// Reset clears control state only; the sample line is masked by a fill count.
// A result not yet taken holds the next scale at the drain step.
// ----------------------------------------------------------------------------
module morlet_filter_bank_convolver_top #(
  parameter int NUM_SCALES  = 16,
  parameter int MAX_TAPS    = 512,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  mfb_pkg::in_t                     in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output mfb_pkg::out_t                    out_o,
  input  logic                             cfg_we_i,
  input  logic [mfb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mfb_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import mfb_pkg::*;

  localparam int TAP_W = $clog2(MAX_TAPS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [9:0]        hw_q;
  logic [4:0]        ns_q;
  logic [WARM_W-1:0] warm_q, warm_d;
  logic [3:0]        scale_q, scale_d;
  logic [TAP_W-1:0]  tap_q, tap_d;
  logic              neg_q, neg_d, first_q, first_d;
  logic              out_valid_q, out_valid_d, out_load;
  out_t              out_q;

  logic [HEFF_W-1:0] h_raw, h_eff, hm1;
  logic [4:0]        ns_eff;
  logic              in_acc, smp_acc, coef_acc, warm_more, tap_last, sc_last;

  line_ctl_t                    line_ctl;
  mac_ctl_t                     mac_ctl;
  logic                         tap_rd;
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [15:0]           re_tap, im_tap;
  logic                         mac_busy;
  logic signed [SUM_W-1:0]      re_sum, im_sum;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q <= HALF_WINDOW_RST;
      ns_q <= SCALES_IN_USE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HALF_WINDOW:   hw_q <= cfg_wdata_i;
        CFG_SCALES_IN_USE: ns_q <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  // Clamped settings
  assign h_raw  = {1'b0, hw_q};
  assign h_eff  = (hw_q == '0) ? HEFF_W'(1) :
                  (h_raw > HEFF_W'(MAX_TAPS)) ? HEFF_W'(MAX_TAPS) : h_raw;
  assign hm1    = h_eff - 1'b1;
  assign ns_eff = (ns_q == '0) ? 5'd1 :
                  (ns_q > 5'(NUM_SCALES)) ? 5'(NUM_SCALES) : ns_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign smp_acc    = in_acc && (in_i.mode == MODE_SAMPLE);
  assign coef_acc   = in_acc && (in_i.mode == MODE_COEF);
  assign warm_more  = ({1'b0, warm_q} < hm1);
  assign tap_last   = !neg_q && (HEFF_W'(tap_q) == hm1);
  assign sc_last    = (({1'b0, scale_q} + 5'd1) == ns_eff);

  // Sequencer: offset walks from the newest sample outward, |k| down then up
  always_comb begin
    state_d  = state_q;
    warm_d   = warm_q;
    scale_d  = scale_q;
    tap_d    = tap_q;
    neg_d    = neg_q;
    first_d  = first_q;
    line_ctl = '0;
    mac_ctl  = '0;
    tap_rd   = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (smp_acc) begin
          line_ctl.push = 1'b1;
          if (warm_more) begin
            warm_d = warm_q + 1'b1;
          end else begin
            if (warm_q != WARM_MAX) warm_d = warm_q + 1'b1;
            line_ctl.rewind = 1'b1;
            scale_d = '0;
            tap_d   = TAP_W'(hm1);
            neg_d   = (hm1 != '0);
            first_d = 1'b1;
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        line_ctl.step = 1'b1;
        tap_rd        = 1'b1;
        mac_ctl.valid = 1'b1;
        mac_ctl.first = first_q;
        mac_ctl.sub   = neg_q;
        first_d       = 1'b0;
        if (neg_q) begin
          if (tap_q == TAP_W'(1)) begin
            tap_d = '0;
            neg_d = 1'b0;
          end else begin
            tap_d = tap_q - 1'b1;
          end
        end else begin
          tap_d = tap_q + 1'b1;
        end
        if (tap_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!mac_busy && !out_valid_q) begin
          out_load = 1'b1;
          if (sc_last) begin
            state_d = ST_IDLE;
          end else begin
            line_ctl.rewind = 1'b1;
            scale_d = scale_q + 1'b1;
            tap_d   = TAP_W'(hm1);
            neg_d   = (hm1 != '0);
            first_d = 1'b1;
            state_d = ST_RUN;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      warm_q  <= '0;
      scale_q <= '0;
      tap_q   <= '0;
      neg_q   <= 1'b0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      warm_q  <= warm_d;
      scale_q <= scale_d;
      tap_q   <= tap_d;
      neg_q   <= neg_d;
      first_q <= first_d;
    end
  end

  // Output register
  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else         out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.scale_out  <= scale_q;
      out_q.real_sum   <= re_sum;
      out_q.imag_sum   <= im_sum;
      out_q.last_scale <= sc_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  mfb_line #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_line (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (line_ctl),
    .push_data_i (SAMPLE_BITS'({16'd0, in_i.sample})),
    .rd_data_o   (x)
  );

  mfb_taps #(
    .NUM_SCALES (NUM_SCALES),
    .MAX_TAPS   (MAX_TAPS)
  ) u_taps (
    .clk_i      (clk_i),
    .wr_en_i    (coef_acc),
    .wr_scale_i (in_i.coef_scale),
    .wr_tap_i   (in_i.coef_tap),
    .wr_real_i  (in_i.coef_real),
    .wr_imag_i  (in_i.coef_imag),
    .rd_en_i    (tap_rd),
    .rd_scale_i (scale_q),
    .rd_tap_i   (tap_q),
    .rd_real_o  (re_tap),
    .rd_imag_o  (im_tap)
  );

  mfb_mac #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (mac_ctl),
    .x_i        (x),
    .re_tap_i   (re_tap),
    .im_tap_i   (im_tap),
    .busy_o     (mac_busy),
    .real_sum_o (re_sum),
    .imag_sum_o (im_sum)
  );

endmodule

// ----- design/mfb_line.sv -----
// ----------------------------------------------------------------------------
// mfb_line: sample delay line
// Circular sample memory with write pointer, backward read pointer and a
// fill count; slots older than the fill count read as zero.
// ----------------------------------------------------------------------------
module mfb_line #(
  parameter int MAX_TAPS    = 512,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mfb_pkg::line_ctl_t            ctl_i,
  input  logic [SAMPLE_BITS-1:0]        push_data_i,
  output logic signed [SAMPLE_BITS-1:0] rd_data_o
);
  import mfb_pkg::*;

  localparam int LINE_DEPTH = 2 * MAX_TAPS;
  localparam int LINE_W     = $clog2(LINE_DEPTH);
  localparam logic [LINE_W-1:0] LAST_SLOT = LINE_W'(LINE_DEPTH - 1);
  localparam logic [LINE_W:0]   FULL      = (LINE_W + 1)'(LINE_DEPTH);

  logic [SAMPLE_BITS-1:0] mem [LINE_DEPTH];
  logic [SAMPLE_BITS-1:0] data_q;
  logic [LINE_W-1:0]      wr_q, wr_d, rd_q, rd_d, j_q, j_d;
  logic [LINE_W:0]        fill_q, fill_d;
  logic                   live_q, live_d;

  // Pointer and fill count update
  always_comb begin
    wr_d   = wr_q;
    fill_d = fill_q;
    rd_d   = rd_q;
    j_d    = j_q;
    live_d = 1'b0;
    if (ctl_i.push) begin
      wr_d = (wr_q == LAST_SLOT) ? '0 : wr_q + 1'b1;
      if (fill_q != FULL) fill_d = fill_q + 1'b1;
    end
    if (ctl_i.rewind) begin
      rd_d = wr_d;
      j_d  = '0;
    end else if (ctl_i.step) begin
      rd_d   = (rd_q == '0) ? LAST_SLOT : rd_q - 1'b1;
      j_d    = j_q + 1'b1;
      live_d = ({1'b0, j_q} < fill_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      j_q    <= '0;
      fill_q <= '0;
      live_q <= 1'b0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      j_q    <= j_d;
      fill_q <= fill_d;
      live_q <= live_d;
    end
  end

  // Memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) mem[wr_d] <= push_data_i;
    if (ctl_i.step) data_q <= mem[rd_q];
  end

  assign rd_data_o = live_q ? signed'(data_q) : '0;

endmodule

// ----- design/mfb_taps.sv -----
// ----------------------------------------------------------------------------
// mfb_taps: wavelet tap tables
// Real and imaginary taps per scale and absolute offset, one memory word per
// pair; out-of-range writes are dropped.
// ----------------------------------------------------------------------------
module mfb_taps #(
  parameter int NUM_SCALES = 16,
  parameter int MAX_TAPS   = 512
) (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [3:0]                  wr_scale_i,
  input  logic [8:0]                  wr_tap_i,
  input  logic signed [15:0]          wr_real_i,
  input  logic signed [15:0]          wr_imag_i,
  input  logic                        rd_en_i,
  input  logic [3:0]                  rd_scale_i,
  input  logic [$clog2(MAX_TAPS)-1:0] rd_tap_i,
  output logic signed [15:0]          rd_real_o,
  output logic signed [15:0]          rd_imag_o
);
  import mfb_pkg::*;

  localparam int DEPTH  = NUM_SCALES * MAX_TAPS;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [31:0]       mem [DEPTH];
  logic [31:0]       rd_q;
  logic              wr_ok;
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  // Address map: scale major, tap minor
  assign wr_ok   = (int'(wr_scale_i) < NUM_SCALES) && (int'(wr_tap_i) < MAX_TAPS);
  assign wr_addr = ADDR_W'(int'(wr_scale_i) * MAX_TAPS + int'(wr_tap_i));
  assign rd_addr = ADDR_W'(int'(rd_scale_i) * MAX_TAPS + int'(rd_tap_i));

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_ok) mem[wr_addr] <= {wr_real_i, wr_imag_i};
    if (rd_en_i) rd_q <= mem[rd_addr];
  end

  assign rd_real_o = signed'(rd_q[31:16]);
  assign rd_imag_o = signed'(rd_q[15:0]);

endmodule

// ----- design/mfb_mac.sv -----
// ----------------------------------------------------------------------------
// mfb_mac: shared complex multiply-accumulate
// One sample times real and imaginary tap per cycle, two accumulators and
// 40-bit saturation of the finished sums.
// ----------------------------------------------------------------------------
module mfb_mac #(
  parameter int MAX_TAPS    = 512,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mfb_pkg::mac_ctl_t               ctl_i,
  input  logic signed [SAMPLE_BITS-1:0]   x_i,
  input  logic signed [15:0]              re_tap_i,
  input  logic signed [15:0]              im_tap_i,
  output logic                            busy_o,
  output logic signed [mfb_pkg::SUM_W-1:0] real_sum_o,
  output logic signed [mfb_pkg::SUM_W-1:0] imag_sum_o
);
  import mfb_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + 16;
  localparam int ACC_W  = PROD_W + $clog2(2 * MAX_TAPS);
  localparam int EXT_W  = (ACC_W > SUM_W) ? ACC_W : SUM_W;
  localparam logic signed [EXT_W-1:0] MAXV = EXT_W'(SUM_MAX);
  localparam logic signed [EXT_W-1:0] MINV = EXT_W'(SUM_MIN);

  mac_ctl_t                  ctl1_q, ctl2_q;
  logic signed [PROD_W-1:0]  pr_q, pi_q;
  logic signed [ACC_W-1:0]   re_q, im_q, term_re, term_im;

  function automatic logic signed [SUM_W-1:0] sat(input logic signed [EXT_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    if (v > MAXV)      r = SUM_MAX;
    else if (v < MINV) r = SUM_MIN;
    else               r = SUM_W'(v);
    return r;
  endfunction

  // Control follows the data through read and multiply stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
    end
  end

  // Multiply stage
  always_ff @(posedge clk_i) begin
    if (ctl1_q.valid) begin
      pr_q <= PROD_W'(x_i) * PROD_W'(re_tap_i);
      pi_q <= PROD_W'(x_i) * PROD_W'(im_tap_i);
    end
  end

  // Accumulate; future offsets subtract on the imaginary side
  assign term_re = ACC_W'(pr_q);
  assign term_im = ctl2_q.sub ? -ACC_W'(pi_q) : ACC_W'(pi_q);

  always_ff @(posedge clk_i) begin
    if (ctl2_q.valid) begin
      re_q <= ctl2_q.first ? term_re : re_q + term_re;
      im_q <= ctl2_q.first ? term_im : im_q + term_im;
    end
  end

  assign busy_o     = ctl1_q.valid | ctl2_q.valid;
  assign real_sum_o = sat(EXT_W'(re_q));
  assign imag_sum_o = sat(EXT_W'(im_q));

endmodule

// ----- design/mfb_checker.sv -----
// ----------------------------------------------------------------------------
// mfb_checker: port-level checks of the filter bank convolver
// Output hold, scale sequencing against request readiness; bound to the top.
// ----------------------------------------------------------------------------
module mfb_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input mfb_pkg::in_t  in_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input mfb_pkg::out_t out_o
);
  import mfb_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed or dropped");

  // A coefficient write leaves the block ready
  a_coef_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_i.mode == MODE_COEF) |=> in_ready_o)
    else $error("coefficient write made the block busy");

  // More scales pending after a non-final result is taken
  a_busy_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_o.last_scale |=> !in_ready_o)
    else $error("ready before the final scale");

  // While ready, a waiting result is the final scale of its position
  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && out_valid_o |-> out_o.last_scale)
    else $error("idle with a non-final result pending");

endmodule

bind morlet_filter_bank_convolver_top mfb_checker u_chk (.*);
